@@ rtl/core/hab_pkg.sv @@
// Shared types, widths and codes for the health-aware backend selector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hab_pkg;

    localparam int MAX_BACKENDS = 8;
    localparam int IDX_W        = 3;
    localparam int MASK_W       = 8;
    localparam int CNT_W        = 4;
    localparam int WEIGHT_W     = 8;
    localparam int WEIGHTS_W    = 64;
    localparam int TOTAL_W      = 11;
    localparam int RAND_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = 4;

    localparam logic       FUNC_SELECT     = 1'b0;
    localparam logic       FUNC_HEALTH     = 1'b1;
    localparam logic       POLICY_WEIGHTED = 1'b0;
    localparam logic       POLICY_RR       = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd2;

    localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 64'h0101_0101_0101_0101;
    localparam logic [CNT_W-1:0]     COUNT_RESET   = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_PICK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [RAND_W-1:0]   dividend;
        logic [TOTAL_W-1:0]  divisor;
    } t_rem_req;

    typedef struct packed {
        logic                done;
        logic [TOTAL_W-1:0]  rem;
    } t_rem_rsp;

endpackage

`default_nettype wire

@@ rtl/core/hab_rem_unit.sv @@
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on hab_pkg for widths and the request and response structs.
`default_nettype none

module hab_rem_unit
    import hab_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_rem_req i_req,
    output t_rem_rsp      o_rsp
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [RAND_W-1:0]   r_dvd, n_dvd;
    logic [TOTAL_W-1:0]  r_div, n_div;
    logic [TOTAL_W-1:0]  r_rem, n_rem;
    logic [TOTAL_W:0]    shifted;
    logic [TOTAL_W:0]    diff;

    always_comb begin
        shifted = {r_rem, r_dvd[RAND_W-1]};
        diff    = shifted - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_dvd   = r_dvd;
        n_div   = r_div;
        n_rem   = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(RAND_W - 1);
            n_dvd  = i_req.dividend;
            n_div  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = (shifted >= {1'b0, r_div}) ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
            n_dvd = {r_dvd[RAND_W-2:0], 1'b0};
            n_step = r_step - STEP_W'(1);
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_dvd  <= n_dvd;
        r_div  <= n_div;
        r_rem  <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

@@ rtl/core/health_aware_backend_selector.sv @@
// Health-aware backend selector. A health update is accepted in ST_IDLE and then passes
// through ST_RESULT. A select is accepted, scans the NUM_BACKENDS slots in ST_SCAN, waits
// in ST_DIV for the shared bit-serial remainder unit, walks the slots in ST_PICK up to a hit
// or the last slot and then gives its result in ST_RESULT. The remainder is the random value
// by the total healthy weight, or the round-robin pointer by the healthy count. A select with
// no healthy backend, or under the weighted policy with zero total weight, skips the
// remainder and pick phases. The block stays in ST_RESULT while a waiting result beat is
// stalled. The input stalls while an item is in work. Configuration writes are always ready
// and must be made while the block is idle.
// Depends on hab_pkg and hab_rem_unit.
`default_nettype none

module health_aware_backend_selector
    import hab_pkg::*;
#(
    parameter int NUM_BACKENDS = MAX_BACKENDS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_func,
    input  wire logic [IDX_W-1:0]      i_backend_index,
    input  wire logic                  i_healthy_flag,
    input  wire logic [RAND_W-1:0]     i_random_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [IDX_W-1:0]           o_selected_backend,
    output logic                       o_found,
    output logic [MASK_W-1:0]          o_health_view,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [WEIGHTS_W-1:0]  i_cfg_data
);

    localparam logic [MASK_W-1:0] ALL_HEALTHY =
        MASK_W'((9'd1 << NUM_BACKENDS) - 9'd1);
    localparam logic [CNT_W-1:0]  NB      = CNT_W'(NUM_BACKENDS);
    localparam logic [IDX_W-1:0]  LAST_IX = IDX_W'(NUM_BACKENDS - 1);

    t_state               r_state, n_state;
    logic [WEIGHTS_W-1:0] r_weights;
    logic [CNT_W-1:0]     r_count;
    logic                 r_policy;
    logic [MASK_W-1:0]    r_health;
    logic [IDX_W-1:0]     r_rr;
    logic [RAND_W-1:0]    r_rnd;
    logic [IDX_W-1:0]     r_i;
    logic [CNT_W-1:0]     r_n;
    logic [TOTAL_W-1:0]   r_sum;
    logic [TOTAL_W-1:0]   r_target;
    logic [IDX_W-1:0]     r_seen;
    logic [IDX_W-1:0]     r_first;
    logic [IDX_W-1:0]     r_sel;
    logic                 r_found;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_sel;
    logic                 r_out_found;
    logic [MASK_W-1:0]    r_out_health;

    logic                 in_accept;
    logic                 out_free;
    logic [CNT_W-1:0]     active_cnt;
    logic                 active;
    logic                 last_i;
    logic [WEIGHT_W-1:0]  w_cur;
    logic [TOTAL_W-1:0]   sum_next;
    logic [TOTAL_W-1:0]   scan_total;
    logic                 pick_hit;
    logic [IDX_W-1:0]     rr_k;
    t_rem_req             rem_req;
    t_rem_rsp             rem_rsp;

    hab_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign active_cnt = (r_count > NB) ? NB : r_count;
    assign active     = ({1'b0, r_i} < active_cnt) && r_health[r_i];
    assign last_i     = (r_i == LAST_IX);
    assign w_cur      = r_weights[r_i*WEIGHT_W +: WEIGHT_W];
    assign sum_next   = r_sum + TOTAL_W'(w_cur);
    assign scan_total = active ? sum_next : r_sum;
    assign rr_k       = rem_rsp.rem[IDX_W-1:0];
    assign pick_hit   = active && ((r_policy == POLICY_WEIGHTED) ?
                                   (r_target <= sum_next) : (r_seen == r_target[IDX_W-1:0]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_func == FUNC_HEALTH) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_i) begin
                    if (r_n == '0 && !active) begin
                        n_state = ST_RESULT;
                    end else if (r_policy == POLICY_WEIGHTED && scan_total == '0) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (rem_rsp.done) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (pick_hit || last_i) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != ST_IDLE);
        o_cfg_ready      = 1'b1;
        rem_req.start    = (r_state == ST_SCAN) && (n_state == ST_DIV);
        rem_req.dividend = (r_policy == POLICY_WEIGHTED) ? r_rnd : RAND_W'(r_rr);
        rem_req.divisor  = (r_policy == POLICY_WEIGHTED) ? scan_total :
                           TOTAL_W'(r_n + CNT_W'(active));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_weights   <= WEIGHTS_RESET;
            r_count     <= COUNT_RESET;
            r_policy    <= POLICY_WEIGHTED;
            r_health    <= ALL_HEALTHY;
            r_rr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_WEIGHTS: r_weights <= i_cfg_data;
                    CFG_COUNT:   r_count   <= i_cfg_data[CNT_W-1:0];
                    CFG_POLICY:  r_policy  <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            if (in_accept && i_func == FUNC_HEALTH && {1'b0, i_backend_index} < NB) begin
                r_health[i_backend_index] <= i_healthy_flag;
            end
            if (r_state == ST_DIV && rem_rsp.done && r_policy == POLICY_RR) begin
                r_rr <= (({1'b0, rr_k} + CNT_W'(1)) == r_n) ? '0 : rr_k + IDX_W'(1);
            end
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_rnd   <= i_random_value;
                r_i     <= '0;
                r_n     <= '0;
                r_sum   <= '0;
                r_first <= '0;
                r_sel   <= '0;
                r_found <= 1'b0;
            end
            ST_SCAN: begin
                if (active) begin
                    if (r_n == '0) begin
                        r_first <= r_i;
                        r_sel   <= r_i;
                        r_found <= 1'b1;
                    end
                    r_n <= r_n + CNT_W'(1);
                end
                r_sum <= scan_total;
                r_i   <= last_i ? '0 : r_i + IDX_W'(1);
            end
            ST_DIV: begin
                r_i    <= '0;
                r_sum  <= '0;
                r_seen <= '0;
                r_sel  <= r_first;
                if (r_policy == POLICY_WEIGHTED) begin
                    r_target <= rem_rsp.rem + TOTAL_W'(1);
                end else begin
                    r_target <= TOTAL_W'(rr_k);
                end
            end
            ST_PICK: begin
                if (active) begin
                    r_sum  <= sum_next;
                    r_seen <= r_seen + IDX_W'(1);
                end
                if (pick_hit) begin
                    r_sel <= r_i;
                end
                r_i <= r_i + IDX_W'(1);
            end
            ST_RESULT: begin
                if (out_free) begin
                    r_out_sel    <= r_sel;
                    r_out_found  <= r_found;
                    r_out_health <= r_health;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_selected_backend = r_out_sel;
    assign o_found            = r_out_found;
    assign o_health_view      = r_out_health;

endmodule

`default_nettype wire

@@ sim/tb_health_aware_backend_selector.sv @@
// Self-checking testbench for the health-aware backend selector: a directed table, then
// randomized phases with register changes, bursty input and an output stall pattern.
// Depends on hab_pkg and the health_aware_backend_selector RTL.
`timescale 1ns / 1ps

module tb_health_aware_backend_selector
    import hab_pkg::*;
;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 75;
    localparam int MAX_REPORTS = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  sel;
        logic              found;
        logic [MASK_W-1:0] view;
    } t_pick;

    typedef enum {ROW_ITEM, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [WEIGHTS_W-1:0]  reg_data;
        logic                  func;
        logic [IDX_W-1:0]      bidx;
        logic                  flag;
        logic [RAND_W-1:0]     rnd;
        bit                    typed;
        t_pick                 want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_func = FUNC_SELECT;
    logic [IDX_W-1:0]     i_backend_index = '0;
    logic                 i_healthy_flag = 1'b0;
    logic [RAND_W-1:0]    i_random_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [IDX_W-1:0]     o_selected_backend;
    logic                 o_found;
    logic [MASK_W-1:0]    o_health_view;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WEIGHTS_W-1:0] i_cfg_data = '0;

    // Shadow copy of the block's registers and state.
    logic [WEIGHTS_W-1:0] weights_now = WEIGHTS_RESET;
    logic [CNT_W-1:0]     count_now = COUNT_RESET;
    logic                 policy_now = POLICY_WEIGHTED;
    logic [MASK_W-1:0]    health_now = '1;
    int                   rr_now = 0;

    t_pick      expected_picks[$];
    t_stim_row  directed_rows[$];
    int         errors = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         empty_selects = 0;
    int         reg_writes = 0;
    int         burst_left = 1;
    int         cycle_count = 0;
    logic [9:0] stall_clock = '0;

    health_aware_backend_selector uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_backend_index    (i_backend_index),
        .i_healthy_flag     (i_healthy_flag),
        .i_random_value     (i_random_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_selected_backend (o_selected_backend),
        .o_found            (o_found),
        .o_health_view      (o_health_view),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_pick pick_backend(input logic f, input logic [IDX_W-1:0] bidx,
                                           input logic hf, input logic [RAND_W-1:0] rv);
        t_pick r;
        int lim, n, total, first, target, sum, k, seen;
        bit done;
        r.sel = '0;
        r.found = 1'b0;
        if (f == FUNC_HEALTH) begin
            if (int'(bidx) < MAX_BACKENDS) begin
                health_now[bidx] = hf;
            end
        end else begin
            lim = (count_now > MAX_BACKENDS) ? MAX_BACKENDS : int'(count_now);
            n = 0;
            total = 0;
            first = 0;
            for (int i = 0; i < lim; i++) begin
                if (health_now[i]) begin
                    if (n == 0) first = i;
                    n++;
                    total += weights_now[i*WEIGHT_W +: WEIGHT_W];
                end
            end
            if (n != 0) begin
                r.found = 1'b1;
                r.sel = first[IDX_W-1:0];
                done = 1'b0;
                if (policy_now == POLICY_WEIGHTED) begin
                    if (total != 0) begin
                        target = (int'(rv) % total) + 1;
                        sum = 0;
                        for (int i = 0; i < lim; i++) begin
                            if (health_now[i] && !done) begin
                                sum += weights_now[i*WEIGHT_W +: WEIGHT_W];
                                if (target <= sum) begin
                                    r.sel = i[IDX_W-1:0];
                                    done = 1'b1;
                                end
                            end
                        end
                    end
                end else begin
                    k = rr_now % n;
                    seen = 0;
                    for (int i = 0; i < lim; i++) begin
                        if (health_now[i] && !done) begin
                            if (seen == k) begin
                                r.sel = i[IDX_W-1:0];
                                done = 1'b1;
                            end
                            seen++;
                        end
                    end
                    rr_now = (rr_now + 1) % n;
                end
            end
        end
        r.view = health_now;
        return r;
    endfunction

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHTS_W-1:0] data);
        t_stim_row row;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = data;
        row.func = FUNC_SELECT;
        row.bidx = '0;
        row.flag = 1'b0;
        row.rnd = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_item(input logic f, input logic [IDX_W-1:0] b, input logic h,
                            input logic [RAND_W-1:0] r, input bit typed,
                            input logic [IDX_W-1:0] sel, input logic fnd,
                            input logic [MASK_W-1:0] view);
        t_stim_row row;
        row.kind = ROW_ITEM;
        row.reg_idx = '0;
        row.reg_data = '0;
        row.func = f;
        row.bidx = b;
        row.flag = h;
        row.rnd = r;
        row.typed = typed;
        row.want.sel = sel;
        row.want.found = fnd;
        row.want.view = view;
        directed_rows = {directed_rows, row};
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken, or after the
    // idle gap that closes a burst.
    task automatic send_beat(input logic f, input logic [IDX_W-1:0] b, input logic h,
                             input logic [RAND_W-1:0] r, input bit typed, input t_pick want);
        t_pick got;
        i_in_valid <= 1'b1;
        i_func <= f;
        i_backend_index <= b;
        i_healthy_flag <= h;
        i_random_value <= r;
        do @(posedge i_clk); while (o_in_stall);
        got = pick_backend(f, b, h, r);
        expected_picks = {expected_picks, (typed ? want : got)};
        items_sent++;
        if (f == FUNC_SELECT && !got.found) empty_selects++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHTS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WEIGHTS: weights_now = data;
            CFG_COUNT:   count_now = data[CNT_W-1:0];
            CFG_POLICY:  policy_now = data[0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_picks.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, got backend %0d found %0b",
                         $time, o_selected_backend, o_found);
            end else begin
                want = expected_picks.pop_front();
                results_seen++;
                if (o_selected_backend !== want.sel) begin
                    flag_mismatch("selected_backend", want.sel, o_selected_backend);
                end
                if (o_found !== want.found) flag_mismatch("found", want.found, o_found);
                if (o_health_view !== want.view) begin
                    flag_mismatch("health_view", want.view, o_health_view);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 1'b1;
        case (t_stall_mode'(stall_clock[9:8]))
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_SPARSE:   i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: i_out_stall <= (stall_clock[4:2] == 3'd0);
            default:        i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_picks.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        t_pick none;
        logic [WEIGHTS_W-1:0] data;
        logic [CNT_W-1:0] cnt;
        int health_pct, heal_pct, pick;
        logic f, h;
        logic [RAND_W-1:0] rv;

        none = '0;
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b1, 3'd0, 1'b1, 8'hFF);
        add_item(FUNC_SELECT, 3'd7, 1'b1, 16'hFFFF, 1'b1, 3'd7, 1'b1, 8'hFF);
        add_item(FUNC_HEALTH, 3'd7, 1'b0, 16'h0000, 1'b1, 3'd0, 1'b0, 8'h7F);
        add_item(FUNC_HEALTH, 3'd0, 1'b0, 16'hFFFF, 1'b1, 3'd0, 1'b0, 8'h7E);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0005, 1'b0, '0, 1'b0, '0);
        add_reg(CFG_POLICY, 64'd1);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b0, '0, 1'b0, '0);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b0, '0, 1'b0, '0);
        add_reg(CFG_COUNT, 64'd15);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b0, '0, 1'b0, '0);
        add_reg(CFG_COUNT, 64'd0);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b1, 3'd0, 1'b0, 8'h7E);
        add_reg(CFG_COUNT, 64'd1);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b1, 3'd0, 1'b0, 8'h7E);
        add_item(FUNC_HEALTH, 3'd0, 1'b1, 16'h0000, 1'b1, 3'd0, 1'b0, 8'h7F);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h0000, 1'b1, 3'd0, 1'b1, 8'h7F);
        add_reg(CFG_COUNT, 64'd8);
        add_reg(CFG_POLICY, 64'd0);
        add_reg(CFG_WEIGHTS, 64'd0);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'hFFFF, 1'b1, 3'd0, 1'b1, 8'h7F);
        add_reg(CFG_WEIGHTS, '1);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'hFFFF, 1'b0, '0, 1'b0, '0);
        add_item(FUNC_HEALTH, 3'd7, 1'b1, 16'h0000, 1'b1, 3'd0, 1'b0, 8'hFF);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h1234, 1'b0, '0, 1'b0, '0);
        add_reg(CFG_WEIGHTS, 64'h0000_0000_0000_FF00);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h8000, 1'b0, '0, 1'b0, '0);
        add_reg(CFG_SPARE, '1);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h00AA, 1'b0, '0, 1'b0, '0);
        add_reg(CFG_WEIGHTS, 64'hFF00_0000_0000_0000);
        add_item(FUNC_SELECT, 3'd0, 1'b0, 16'h7FFF, 1'b0, '0, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[j]) begin
            row = directed_rows[j];
            if (row.kind == ROW_REG) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_beat(row.func, row.bidx, row.flag, row.rnd, row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case ($urandom_range(0, 5))
                0: data = {$urandom, $urandom};
                1: data = '0;
                2: data = '1;
                3: begin
                    for (int b = 0; b < MAX_BACKENDS; b++) begin
                        data[b*WEIGHT_W +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 3));
                    end
                end
                4: begin
                    data = {$urandom, $urandom};
                    for (int b = 0; b < MAX_BACKENDS; b++) begin
                        if ($urandom_range(0, 1) == 0) data[b*WEIGHT_W +: WEIGHT_W] = '0;
                    end
                end
                default: begin
                    data = '0;
                    data[$urandom_range(0, MAX_BACKENDS - 1)*WEIGHT_W +: WEIGHT_W] =
                        WEIGHT_W'($urandom_range(1, 255));
                end
            endcase
            write_reg(CFG_WEIGHTS, data);
            pick = $urandom_range(0, 11);
            if (pick < 8) cnt = CNT_W'(pick + 1);
            else if (pick < 10) cnt = CNT_W'(MAX_BACKENDS);
            else if (pick == 10) cnt = '0;
            else cnt = CNT_W'($urandom_range(9, 15));
            data = {$urandom, $urandom};
            data[CNT_W-1:0] = cnt;
            write_reg(CFG_COUNT, data);
            data = {$urandom, $urandom};
            data[0] = (p % 2 == 0) ? POLICY_WEIGHTED : POLICY_RR;
            write_reg(CFG_POLICY, data);
            if ($urandom_range(0, 4) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});

            health_pct = $urandom_range(10, 50);
            heal_pct = $urandom_range(30, 90);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                f = ($urandom_range(0, 99) < health_pct) ? FUNC_HEALTH : FUNC_SELECT;
                h = ($urandom_range(0, 99) < heal_pct);
                case ($urandom_range(0, 5))
                    0: rv = '0;
                    1: rv = '1;
                    2: rv = RAND_W'($urandom_range(0, 64));
                    default: rv = RAND_W'($urandom);
                endcase
                send_beat(f, IDX_W'($urandom_range(0, MAX_BACKENDS - 1)), h, rv, 1'b0, none);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (expected_picks.size() != 0) begin
            errors += expected_picks.size();
            $display("%0d expected results never arrived", expected_picks.size());
        end
        $display("Sent %0d items (%0d selects found no backend), compared %0d results,",
                 items_sent, empty_selects, results_seen);
        $display("made %0d register writes over %0d randomized phases.", reg_writes, PHASES);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
